/* rtl/usbrd_pkg.sv */
// ----------------------------------------------------------------------------
// Reply deframer package
// Shared types, register map and status codes of the reply deframer.
// ----------------------------------------------------------------------------
package usbrd_pkg;

  localparam int unsigned CHUNK_BYTES_DEF = 64;
  localparam int unsigned MAX_TRANSFER    = 32768;
  localparam logic [15:0] SIZE_LIMIT      = 16'(MAX_TRANSFER - 3);

  localparam logic [7:0]  CHECK_BASE      = 8'haa;
  localparam logic [7:0]  TYPE_RESET      = 8'hb0;
  localparam logic [7:0]  FIXED_RESET     = 8'h88;

  localparam int unsigned ADDR_W          = 4;

  typedef enum logic [1:0] {
    REG_EXPECTED_TYPE = 2'd0,
    REG_FIXED_ENABLE  = 2'd1,
    REG_FIXED_VALUE   = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TYPE_BAD  = 2'd1,
    ST_CHECK_BAD = 2'd2,
    ST_LEN_BAD   = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] expected_type;
    logic       fixed_check_enable;
    logic [7:0] fixed_check_value;
  } cfg_t;

endpackage

/* rtl/usbrd_if.sv */
// ----------------------------------------------------------------------------
// Reply deframer channels
// Valid/ready channels for raw input bytes and for result items.
// ----------------------------------------------------------------------------
interface usbrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       transfer_start;

  modport source (output valid, output rx_byte, output transfer_start, input ready);
  modport sink   (input valid, input rx_byte, input transfer_start, output ready);
endinterface

interface usbrd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        is_final;
  logic [1:0]  status;
  logic [14:0] data_length;

  modport source (output valid, output out_byte, output is_final, output status,
                  output data_length, input ready);
  modport sink   (input valid, input out_byte, input is_final, input status,
                  input data_length, output ready);
endinterface

/* rtl/usb_reply_deframe_checksum.sv */
// Each input item is held in the input register and its result item, if any, in the
// result register; a result item waiting on out_ch.ready holds the next item back.
// Throughput: one input item per cycle; while a result waits, one more item can enter
// the input register and the input then stalls. Each item yields at most one result.
// Reset (rst_n, synchronous, active low) clears the parse state and both valid flags
// and loads the register defaults: expected type 0xb0, fixed check off, value 0x88.
// ----------------------------------------------------------------------------
// Reply deframer with checksum check
// Parses type and size, drops chunk continuation bytes, emits data and status.
// ----------------------------------------------------------------------------
module usb_reply_deframe_checksum #(
  parameter int unsigned CHUNK_BYTES = usbrd_pkg::CHUNK_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  usbrd_in_if.sink                      in_ch,
  usbrd_out_if.source                   out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [usbrd_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import usbrd_pkg::*;

  cfg_t cfg;

  usbrd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  usbrd_deframe #(
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_deframe (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

/* rtl/usbrd_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Reply deframer configuration registers
// APB-style register file holding the expected type and the fixed checksum.
// ----------------------------------------------------------------------------
module usbrd_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [usbrd_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output usbrd_pkg::cfg_t               cfg
);
  import usbrd_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.expected_type      <= TYPE_RESET;
      cfg_r.fixed_check_enable <= 1'b0;
      cfg_r.fixed_check_value  <= FIXED_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_EXPECTED_TYPE: cfg_r.expected_type      <= pwdata[7:0];
        REG_FIXED_ENABLE:  cfg_r.fixed_check_enable <= pwdata[0];
        REG_FIXED_VALUE:   cfg_r.fixed_check_value  <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_EXPECTED_TYPE: prdata = {24'd0, cfg_r.expected_type};
      REG_FIXED_ENABLE:  prdata = {31'd0, cfg_r.fixed_check_enable};
      REG_FIXED_VALUE:   prdata = {24'd0, cfg_r.fixed_check_value};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

/* rtl/usbrd_deframe.sv */
// ----------------------------------------------------------------------------
// Reply deframer datapath
// Input register, per-byte parse and checksum logic, and result register.
// ----------------------------------------------------------------------------
module usbrd_deframe #(
  parameter int unsigned CHUNK_BYTES = usbrd_pkg::CHUNK_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  usbrd_pkg::cfg_t cfg,
  usbrd_in_if.sink        in_ch,
  usbrd_out_if.source     out_ch
);
  import usbrd_pkg::*;

  localparam int unsigned PosW = $clog2(CHUNK_BYTES);

  typedef enum logic [2:0] {
    PH_IDLE, PH_SIZE_LO, PH_SIZE_HI, PH_DATA, PH_CHECK
  } phase_t;

  logic             s1_valid_r;
  logic [7:0]       s1_byte_r;
  logic             s1_start_r;
  logic             s1_adv;

  phase_t           phase_r, phase_nxt;
  logic [PosW-1:0]  pos_r, pos_nxt, pos_inc;
  logic [15:0]      rem_r, rem_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [15:0]      size_r, size_nxt;
  logic [15:0]      size_full;
  logic [7:0]       calc;
  logic [7:0]       cmp;
  logic             cont;

  logic             emit;
  logic [7:0]       emit_byte;
  logic             emit_final;
  status_t          emit_status;
  logic [14:0]      emit_len;
  logic [14:0]      decl_len;

  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_final_r;
  status_t          out_status_r;
  logic [14:0]      out_len_r;

  assign s1_adv       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_byte_r  <= in_ch.rx_byte;
      s1_start_r <= in_ch.transfer_start;
    end
  end

  assign pos_inc   = (pos_r == PosW'(CHUNK_BYTES - 1)) ? '0 : pos_r + PosW'(1);
  assign cont      = (pos_r == '0);
  assign size_full = {s1_byte_r, size_r[7:0]};
  assign decl_len  = 15'(size_r - 16'd1);
  assign calc      = CHECK_BASE - sum_r;
  assign cmp       = cfg.fixed_check_enable ? cfg.fixed_check_value : s1_byte_r;

  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    rem_nxt     = rem_r;
    sum_nxt     = sum_r;
    size_nxt    = size_r;
    emit        = 1'b0;
    emit_byte   = 8'd0;
    emit_final  = 1'b0;
    emit_status = ST_OK;
    emit_len    = 15'd0;
    if (s1_start_r) begin
      sum_nxt  = s1_byte_r;
      pos_nxt  = PosW'(1);
      size_nxt = 16'd0;
      rem_nxt  = 16'd0;
      if (s1_byte_r != cfg.expected_type) begin
        phase_nxt   = PH_IDLE;
        emit        = 1'b1;
        emit_final  = 1'b1;
        emit_status = ST_TYPE_BAD;
      end else begin
        phase_nxt = PH_SIZE_LO;
      end
    end else if (phase_r != PH_IDLE) begin
      pos_nxt = pos_inc;
      case (phase_r)
        PH_SIZE_LO: begin
          size_nxt  = {8'd0, s1_byte_r};
          sum_nxt   = sum_r + s1_byte_r;
          phase_nxt = PH_SIZE_HI;
        end
        PH_SIZE_HI: begin
          size_nxt = size_full;
          sum_nxt  = sum_r + s1_byte_r;
          if (size_full == 16'd0 || size_full > SIZE_LIMIT) begin
            phase_nxt   = PH_IDLE;
            emit        = 1'b1;
            emit_final  = 1'b1;
            emit_status = ST_LEN_BAD;
          end else begin
            rem_nxt   = size_full - 16'd1;
            phase_nxt = (size_full == 16'd1) ? PH_CHECK : PH_DATA;
          end
        end
        PH_DATA: begin
          if (!cont) begin
            sum_nxt   = sum_r + s1_byte_r;
            rem_nxt   = rem_r - 16'd1;
            phase_nxt = (rem_r == 16'd1) ? PH_CHECK : PH_DATA;
            emit      = 1'b1;
            emit_byte = s1_byte_r;
            emit_len  = decl_len;
          end
        end
        PH_CHECK: begin
          if (!cont) begin
            phase_nxt   = PH_IDLE;
            emit        = 1'b1;
            emit_final  = 1'b1;
            emit_status = (calc == cmp) ? ST_OK : ST_CHECK_BAD;
            emit_len    = decl_len;
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      pos_r       <= '0;
      rem_r       <= 16'd0;
      sum_r       <= 8'd0;
      size_r      <= 16'd0;
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      rem_r       <= rem_nxt;
      sum_r       <= sum_nxt;
      size_r      <= size_nxt;
      out_valid_r <= emit;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && emit) begin
      out_byte_r   <= emit_byte;
      out_final_r  <= emit_final;
      out_status_r <= emit_status;
      out_len_r    <= emit_len;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.is_final    = out_final_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.data_length = out_len_r;

  a_check_rem_zero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_CHECK |-> rem_r == 16'd0)
    else $error("checksum phase entered with data bytes outstanding");

  a_data_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> rem_r != 16'd0)
    else $error("data phase with no data bytes outstanding");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= PosW'(CHUNK_BYTES - 1))
    else $error("chunk position out of range");

  a_data_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_final_r |-> out_status_r == ST_OK)
    else $error("data item carries a nonzero status");

  a_stall_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_ch.ready |=> s1_valid_r)
    else $error("pending item lost while the result was stalled");

endmodule
